@@ src/sobel_pkg.sv @@
// ----------------------------------------------------------------------------
// Sobel gradient package
// Shared types, register indexes and sizing constants for the Sobel block.
// ----------------------------------------------------------------------------
package sobel_pkg;

  // Default line memory depth: the widest row the block can hold.
  localparam int MAX_WIDTH_DEF = 2048;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  // Field widths.
  localparam int GRAY_W = 8;
  localparam int GRAD_W = 11;
  localparam int COL_W  = 11;
  localparam int ROW_W  = 12;

  // One entry of the line memory: the gray levels one and two rows above.
  typedef struct packed {
    logic [GRAY_W-1:0] above1;
    logic [GRAY_W-1:0] above2;
  } line_pair_t;

  // One new window column, top to bottom.
  typedef struct packed {
    logic [GRAY_W-1:0] top;
    logic [GRAY_W-1:0] mid;
    logic [GRAY_W-1:0] bot;
  } win_col_t;

  // One result item.
  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [COL_W-1:0]         center_col;
    logic [ROW_W-1:0]         center_row;
    logic                     frame_last;
  } result_t;

endpackage

@@ src/sobel_line_mem.sv @@
// ----------------------------------------------------------------------------
// Sobel line memory
// Single-port-write, registered-read memory holding the two previous rows.
// ----------------------------------------------------------------------------
module sobel_line_mem #(
  parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  output sobel_pkg::line_pair_t  rd_data,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  sobel_pkg::line_pair_t  wr_data
);
  import sobel_pkg::*;

  line_pair_t mem [MAX_WIDTH];
  line_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/sobel_window.sv @@
// ----------------------------------------------------------------------------
// Sobel window
// Holds the two older window columns and forms both gradients of the window
// that the incoming column completes.
// ----------------------------------------------------------------------------
module sobel_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  sobel_pkg::win_col_t           col_new,
  output logic signed [sobel_pkg::GRAD_W-1:0] grad_x,
  output logic signed [sobel_pkg::GRAD_W-1:0] grad_y
);
  import sobel_pkg::*;

  localparam int SW = GRAD_W + 1;

  // col0_r is the leftmost column, col1_r the middle one.
  win_col_t col0_r, col1_r;

  logic signed [SW-1:0] t0, t1, t2, m0, m2, b0, b1, b2;
  logic signed [SW-1:0] gx_full, gy_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col0_r <= '0;
      col1_r <= '0;
    end else if (step) begin
      col0_r <= col1_r;
      col1_r <= col_new;
    end
  end

  always_comb begin
    t0 = $signed({{(SW-GRAY_W){1'b0}}, col0_r.top});
    t1 = $signed({{(SW-GRAY_W){1'b0}}, col1_r.top});
    t2 = $signed({{(SW-GRAY_W){1'b0}}, col_new.top});
    m0 = $signed({{(SW-GRAY_W){1'b0}}, col0_r.mid});
    m2 = $signed({{(SW-GRAY_W){1'b0}}, col_new.mid});
    b0 = $signed({{(SW-GRAY_W){1'b0}}, col0_r.bot});
    b1 = $signed({{(SW-GRAY_W){1'b0}}, col1_r.bot});
    b2 = $signed({{(SW-GRAY_W){1'b0}}, col_new.bot});
    // Right minus left, middle row weighted twice.
    gx_full = (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
    // Bottom minus top, middle column weighted twice.
    gy_full = (b0 - t0) + ((b1 - t1) <<< 1) + (b2 - t2);
  end

  assign grad_x = gx_full[GRAD_W-1:0];
  assign grad_y = gy_full[GRAD_W-1:0];

endmodule

@@ src/sobel_out_buf.sv @@
// ----------------------------------------------------------------------------
// Sobel output buffer
// Three-entry result queue that decouples the pipeline from the consumer.
// ----------------------------------------------------------------------------
module sobel_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sobel_pkg::result_t  push_data,
  input  logic                pending,
  output logic                block_in,
  output logic                out_valid,
  input  logic                out_stall,
  output sobel_pkg::result_t  out_data
);
  import sobel_pkg::*;

  localparam int DEPTH = 3;
  localparam int PTR_W = 2;
  localparam int CNT_W = 2;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] NEAR_CNT = CNT_W'(DEPTH - 1);

  result_t          entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = entry_r[rd_ptr_r];

  // An item entering now reaches the queue in the next cycle; refuse it unless
  // a slot is sure to be free by then, counting the result already in flight.
  assign block_in = (cnt_r == FULL_CNT) || ((cnt_r == NEAR_CNT) && pending);

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ src/sobel_gradient_3x3.sv @@
// ----------------------------------------------------------------------------
// Sobel gradient 3x3
// Converts a raster stream of RGB pixels to gray levels and gives the
// horizontal and vertical Sobel gradients of every interior pixel.
// ----------------------------------------------------------------------------
// Results pass the memory stage registers and the result queue. Throughput:
// one item per cycle while in_stall is low; the line memory is read once per
// item and written once in the cycle after, so its single write port sets the rate.
// Reset: counters clear, the window clears to zero, the frame size returns
// to 640 x 480 (width capped at MAX_WIDTH). The line memory is not cleared.
// ----------------------------------------------------------------------------
module sobel_gradient_3x3 #(
  parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration writes.
  input  logic                                cfg_we,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Pixel input.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [23:0]                         in_pixel_rgb,
  // Results.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sobel_pkg::GRAD_W-1:0] out_grad_x,
  output logic signed [sobel_pkg::GRAD_W-1:0] out_grad_y,
  output logic [sobel_pkg::COL_W-1:0]         out_center_col,
  output logic [sobel_pkg::ROW_W-1:0]         out_center_row,
  output logic                                out_frame_last
);
  import sobel_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  // The column counter is 11 bits wide, so rows never exceed 2048 pixels.
  localparam int WIDTH_LIM = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int HEIGHT_LIM = 4096;
  localparam int MIN_SIZE = 3;
  localparam int FW_W = 12;
  localparam int FH_W = 13;
  // Frame size after reset, with the width held to what the memory holds.
  localparam int RESET_WIDTH  = (640 < WIDTH_LIM) ? 640 : WIDTH_LIM;
  localparam int RESET_HEIGHT = 480;

  // Gray level = sum / 3, done as sum * 683 >> 11, exact for sums up to 765.
  localparam int SUM_W      = 10;
  localparam int PROD_W     = 20;
  localparam int GRAY_SHIFT = 11;
  localparam logic [SUM_W-1:0] GRAY_RECIP = SUM_W'(683);

  // The block emits once two columns and two rows have filled the window.
  localparam logic [COL_W-1:0] FIRST_COL = COL_W'(2);
  localparam logic [ROW_W-1:0] FIRST_ROW = ROW_W'(2);

  // --------------------------------------------------------------------------
  // Configuration. Only the last column and last row indexes in use are kept,
  // already clamped to the supported range.
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] last_col_idx_r;
  logic [ROW_W-1:0] last_row_idx_r;
  logic [FW_W-1:0]  fw_raw, fw_clamped;
  logic [FH_W-1:0]  fh_raw, fh_clamped;

  always_comb begin
    fw_raw = cfg_wdata[FW_W-1:0];
    fh_raw = cfg_wdata[FH_W-1:0];
    if (fw_raw < FW_W'(MIN_SIZE)) begin
      fw_clamped = FW_W'(MIN_SIZE);
    end else if (fw_raw > FW_W'(WIDTH_LIM)) begin
      fw_clamped = FW_W'(WIDTH_LIM);
    end else begin
      fw_clamped = fw_raw;
    end
    if (fh_raw < FH_W'(MIN_SIZE)) begin
      fh_clamped = FH_W'(MIN_SIZE);
    end else if (fh_raw > FH_W'(HEIGHT_LIM)) begin
      fh_clamped = FH_W'(HEIGHT_LIM);
    end else begin
      fh_clamped = fh_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_idx_r <= COL_W'(RESET_WIDTH - 1);
      last_row_idx_r <= ROW_W'(RESET_HEIGHT - 1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          last_col_idx_r <= COL_W'(fw_clamped - 1'b1);
        end
        CFG_FRAME_HEIGHT: begin
          last_row_idx_r <= ROW_W'(fh_clamped - 1'b1);
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage. The gray level and the raster position are worked out as
  // the item is taken, and the line memory read for this column is issued.
  // --------------------------------------------------------------------------
  logic              in_accept;
  logic [SUM_W-1:0]  rgb_sum;
  logic [PROD_W-1:0] gray_prod;
  logic [GRAY_W-1:0] gray;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              is_last_col, is_last_row;
  logic [ADDR_W-1:0] rd_addr;
  logic              block_in;

  assign in_stall  = block_in;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    rgb_sum   = SUM_W'(in_pixel_rgb[23:16]) + SUM_W'(in_pixel_rgb[15:8])
              + SUM_W'(in_pixel_rgb[7:0]);
    gray_prod = PROD_W'(rgb_sum) * PROD_W'(GRAY_RECIP);
    gray      = gray_prod[GRAY_SHIFT +: GRAY_W];
  end

  // A counter left beyond the row end by a narrower width wraps on its
  // next step, hence the compare instead of an equality test.
  assign is_last_col = (col_r >= last_col_idx_r);
  assign is_last_row = (row_r >= last_row_idx_r);
  assign rd_addr     = (32'(col_r) < MAX_WIDTH) ? ADDR_W'(col_r) : '0;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (is_last_col) begin
      col_nxt = '0;
      row_nxt = is_last_row ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Memory stage. The line pair arrives from the memory; the new gray level
  // moves into the first line and the old first line into the second, at the
  // same address. Successive items never share a column, so a read never
  // meets a pending write to its own entry.
  // --------------------------------------------------------------------------
  logic              s1_valid_r;
  logic              s1_emit_r;
  logic [GRAY_W-1:0] s1_gray_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [COL_W-1:0]  s1_ccol_r;
  logic [ROW_W-1:0]  s1_crow_r;
  logic              s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
      s1_emit_r  <= in_accept && (col_r >= FIRST_COL) && (row_r >= FIRST_ROW);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_gray_r <= gray;
      s1_addr_r <= rd_addr;
      s1_ccol_r <= col_r - 1'b1;
      s1_crow_r <= row_r - 1'b1;
      s1_last_r <= is_last_col && is_last_row;
    end
  end

  line_pair_t rd_pair;
  line_pair_t wr_pair;

  assign wr_pair.above1 = s1_gray_r;
  assign wr_pair.above2 = rd_pair.above1;

  sobel_line_mem #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_pair),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_pair)
  );

  // --------------------------------------------------------------------------
  // Window and gradients. The new column is the two stored rows above and
  // the current gray level.
  // --------------------------------------------------------------------------
  win_col_t                 new_col;
  logic signed [GRAD_W-1:0] grad_x, grad_y;

  assign new_col.top = rd_pair.above2;
  assign new_col.mid = rd_pair.above1;
  assign new_col.bot = s1_gray_r;

  sobel_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_valid_r),
    .col_new (new_col),
    .grad_x  (grad_x),
    .grad_y  (grad_y)
  );

  // --------------------------------------------------------------------------
  // Result queue.
  // --------------------------------------------------------------------------
  result_t res_in, res_out;

  assign res_in.grad_x     = grad_x;
  assign res_in.grad_y     = grad_y;
  assign res_in.center_col = s1_ccol_r;
  assign res_in.center_row = s1_crow_r;
  assign res_in.frame_last = s1_last_r;

  sobel_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_emit_r),
    .push_data (res_in),
    .pending   (s1_emit_r),
    .block_in  (block_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  assign out_grad_x     = res_out.grad_x;
  assign out_grad_y     = res_out.grad_y;
  assign out_center_col = res_out.center_col;
  assign out_center_row = res_out.center_row;
  assign out_frame_last = res_out.frame_last;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Sobel gradient 3x3 testbench
// Streams RGB pixel frames of many sizes through the block with random idle
// cycles on both channels. A behavioral model of the gray conversion, line
// memory, window and counters predicts every result item, and each result
// item is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import sobel_pkg::*;

  localparam int LINE_DEPTH   = MAX_WIDTH_DEF;
  localparam int CYCLE_LIMIT  = 100_000;
  // Margin for the pipeline to empty after the last predicted result.
  localparam int DRAIN_CYCLES = 4;

  // How random pixels of a frame are made.
  typedef enum int {
    PIX_NOISE,
    PIX_BINARY,
    PIX_GRAY
  } pixel_style_t;

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index    = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]    cfg_wdata    = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic [23:0]              in_pixel_rgb = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic signed [GRAD_W-1:0] out_grad_x;
  logic signed [GRAD_W-1:0] out_grad_y;
  logic [COL_W-1:0]         out_center_col;
  logic [ROW_W-1:0]         out_center_row;
  logic                     out_frame_last;

  sobel_gradient_3x3 u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_rgb   (in_pixel_rgb),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_grad_x     (out_grad_x),
    .out_grad_y     (out_grad_y),
    .out_center_col (out_center_col),
    .out_center_row (out_center_row),
    .out_frame_last (out_frame_last)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral copy of the block state.
  // --------------------------------------------------------------------------
  bit [11:0]    frame_width_reg  = 12'd640;
  bit [12:0]    frame_height_reg = 13'd480;
  bit [7:0]     line_above1 [LINE_DEPTH];
  bit [7:0]     line_above2 [LINE_DEPTH];
  bit [7:0]     gray_win [3][3];
  bit [10:0]    pos_col = '0;
  bit [11:0]    pos_row = '0;

  result_t      expected_grads [$];
  result_t      want;
  int           mismatches      = 0;
  int           pixels_sent     = 0;
  int           cycle_count     = 0;
  int           sender_idle_pct   = 16;
  int           receiver_idle_pct = 69;
  pixel_style_t pix_style = PIX_NOISE;

  // Register values are clamped to what the line memory and row counter hold.
  function automatic int width_used();
    int w;
    w = frame_width_reg;
    if (w < 3) w = 3;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int height_used();
    int h;
    h = frame_height_reg;
    if (h < 3) h = 3;
    if (h > 4096) h = 4096;
    return h;
  endfunction

  // Advances the model by one accepted pixel and queues the gradient result
  // when the pixel completes the window of an interior center pixel.
  function automatic void predict_gradient(input logic [23:0] pix);
    int        gray;
    int        gx;
    int        gy;
    bit [7:0]  up1;
    bit [7:0]  up2;
    bit        last_col;
    bit        last_row;
    result_t   res;
    gray = (int'(pix[23:16]) + int'(pix[15:8]) + int'(pix[7:0])) / 3;
    up1 = line_above1[pos_col];
    up2 = line_above2[pos_col];
    last_col = (pos_col >= width_used() - 1);
    last_row = (pos_row >= height_used() - 1);
    line_above2[pos_col] = up1;
    line_above1[pos_col] = gray[7:0];
    for (int k = 0; k < 3; k++) begin
      gray_win[k][0] = gray_win[k][1];
      gray_win[k][1] = gray_win[k][2];
    end
    gray_win[0][2] = up2;
    gray_win[1][2] = up1;
    gray_win[2][2] = gray[7:0];
    if (pos_col >= 2 && pos_row >= 2) begin
      gx = (int'(gray_win[0][2]) - int'(gray_win[0][0]))
         + 2 * (int'(gray_win[1][2]) - int'(gray_win[1][0]))
         + (int'(gray_win[2][2]) - int'(gray_win[2][0]));
      gy = (int'(gray_win[2][0]) - int'(gray_win[0][0]))
         + 2 * (int'(gray_win[2][1]) - int'(gray_win[0][1]))
         + (int'(gray_win[2][2]) - int'(gray_win[0][2]));
      res.grad_x     = gx[GRAD_W-1:0];
      res.grad_y     = gy[GRAD_W-1:0];
      res.center_col = pos_col - 11'd1;
      res.center_row = pos_row - 12'd1;
      res.frame_last = last_col && last_row;
      expected_grads.push_back(res);
    end
    // A counter at or past the last column (row) in use wraps to zero.
    if (last_col) begin
      pos_col = '0;
      pos_row = last_row ? '0 : pos_row + 12'd1;
    end else begin
      pos_col = pos_col + 11'd1;
    end
  endfunction

  function automatic logic [23:0] random_pixel();
    logic [7:0] g;
    case (pix_style)
      PIX_BINARY: return ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000;
      PIX_GRAY: begin
        g = 8'($urandom_range(255));
        return {g, g, g};
      end
      default: return 24'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Pixel sender. Valid is raised for the item and left high after it is
  // accepted; the next call either reuses it or drops it for an idle cycle.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input logic [23:0] pix);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel_rgb <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_gradient(pix);
    pixels_sent++;
  endtask

  // Sends random pixels until the next pixel position is (col, row).
  task automatic send_until(input int col, input int row);
    while (pos_col != col || pos_row != row) send_pixel(random_pixel());
  endtask

  // Sends random pixels up to the end of the current frame, or one whole
  // frame when at its start.
  task automatic finish_frame();
    do send_pixel(random_pixel()); while (pos_col != 0 || pos_row != 0);
  endtask

  // Stops sending and waits until every predicted result has come out and
  // the pipeline has had time to empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block empty.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) frame_width_reg = value[11:0];
    else frame_height_reg = value;
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stall. The stall is drawn every cycle, so a
  // stall can land on any cycle of the block's work.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_grads.size() == 0) begin
        mismatches++;
        $display("%0t: expected no item, actual gx=%0d gy=%0d col=%0d row=%0d last=%0b",
                 $time, out_grad_x, out_grad_y, out_center_col, out_center_row,
                 out_frame_last);
      end else begin
        want = expected_grads.pop_front();
        if (out_grad_x !== want.grad_x) begin
          mismatches++;
          $display("%0t: grad_x expected %0d, actual %0d", $time,
                   $signed(want.grad_x), out_grad_x);
        end
        if (out_grad_y !== want.grad_y) begin
          mismatches++;
          $display("%0t: grad_y expected %0d, actual %0d", $time,
                   $signed(want.grad_y), out_grad_y);
        end
        if (out_center_col !== want.center_col) begin
          mismatches++;
          $display("%0t: center_col expected %0d, actual %0d", $time,
                   want.center_col, out_center_col);
        end
        if (out_center_row !== want.center_row) begin
          mismatches++;
          $display("%0t: center_row expected %0d, actual %0d", $time,
                   want.center_row, out_center_row);
        end
        if (out_frame_last !== want.frame_last) begin
          mismatches++;
          $display("%0t: frame_last expected %0b, actual %0b", $time,
                   want.frame_last, out_frame_last);
        end
      end
    end
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Watchdog: a hung handshake or a missing result ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset width is 640. One full row goes in at that width, then the frame
  // is cut to 3 x 3, so the wrap after column 639 shows in the row indexes.
  task automatic test_default_frame();
    pix_style = PIX_NOISE;
    send_until(0, 1);
    set_frame(13'd3, 13'd3);
    finish_frame();
  endtask

  // Hard black and white edges drive both gradients to their full range,
  // then a frame of odd channel mixes checks the truncated gray mean.
  task automatic test_gradient_extremes();
    logic [23:0] mixes [9];
    mixes = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h010100, 24'h020202,
              24'hFEFFFF, 24'h808080, 24'h7F7F7F, 24'hFFFF00};
    // Columns white, black, black, white: gx goes to -1020 and +1020.
    set_frame(13'd4, 13'd3);
    repeat (3) begin
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
    end
    // Rows white, black, black, white: gy goes to -1020 and +1020.
    set_frame(13'd3, 13'd4);
    repeat (3) send_pixel(24'hFFFFFF);
    repeat (6) send_pixel(24'h000000);
    repeat (3) send_pixel(24'hFFFFFF);
    set_frame(13'd3, 13'd3);
    foreach (mixes[i]) send_pixel(mixes[i]);
  endtask

  // Narrowing mid-frame: the column counter sits past the new last column
  // and must wrap, then the row counter sits past the new last row. The width
  // write also carries a set bit above the 12-bit register.
  task automatic test_midframe_resize();
    pix_style = PIX_NOISE;
    set_frame(13'd10, 13'd8);
    send_until(7, 3);
    write_reg(CFG_FRAME_WIDTH, 13'h1006);
    send_until(2, 4);
    write_reg(CFG_FRAME_HEIGHT, 13'd4);
    finish_frame();
  endtask

  // Mostly small frames with random content; some sizes fall below the legal range,
  // some widths set a bit above the register, some frames get narrowed partway through.
  task automatic test_random_frames(input int num_items);
    int start;
    int sel;
    int w;
    int h;
    int cut;
    start = pixels_sent;
    while (pixels_sent - start < num_items) begin
      sel = $urandom_range(9);
      if (sel < 7) w = $urandom_range(3, 12);
      else if (sel == 7) w = $urandom_range(0, 2);
      else if (sel == 8) w = $urandom_range(13, 48);
      else w = 'h1000 | $urandom_range(3, 12);
      h = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      set_frame(w[CFG_DATA_W-1:0], h[CFG_DATA_W-1:0]);
      pix_style = pixel_style_t'($urandom_range(2));
      if ($urandom_range(7) == 0) begin
        cut = $urandom_range(1, width_used() * height_used() - 1);
        repeat (cut) send_pixel(random_pixel());
        if ($urandom_range(1) != 0)
          write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(3, width_used())));
        else
          write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(3, height_used())));
        // The frame is still open after the write, since the cut stops short of its end.
        if (pos_col != 0 || pos_row != 0) finish_frame();
      end else begin
        finish_frame();
      end
    end
  endtask

  // Clamps on both registers; the oversized frames are cut short.
  task automatic test_size_extremes();
    pix_style = PIX_NOISE;
    set_frame(13'd0, 13'd3);
    finish_frame();
    // 4095 clamps to 2048 columns, 0 rows clamps to 3; the row is cut to
    // three columns after a short run.
    set_frame(13'd4095, 13'd0);
    send_until(20, 0);
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    finish_frame();
    // 1 column clamps to 3; the 4096-row frame is cut to six rows.
    set_frame(13'd1, 13'd4096);
    send_until(0, 5);
    write_reg(CFG_FRAME_HEIGHT, 13'd6);
    finish_frame();
    // 8191 clamps to 4096 rows; cut short after three rows.
    set_frame(13'd3, 13'd8191);
    send_until(0, 3);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    finish_frame();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frame();
    test_gradient_extremes();
    test_midframe_resize();
    test_random_frames(450);

    sender_idle_pct   = 69;
    receiver_idle_pct = 16;
    test_random_frames(450);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_frames(350);
    test_size_extremes();

    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sobel_pkg.sv
src/sobel_line_mem.sv
src/sobel_window.sv
src/sobel_out_buf.sv
src/sobel_gradient_3x3.sv
sim/testbench.sv
